@@ hw/rtl/clps_pkg.sv @@
`default_nettype none

package clps_pkg;

  // screen and frame geometry
  localparam int unsigned SCREEN_WIDTH_PX  = 480;
  localparam int unsigned SCREEN_HEIGHT_PX = 272;
  localparam int unsigned ROW_PITCH_PIXELS = 512;
  localparam int unsigned FRAME_BYTES      = 278528;
  localparam int unsigned PIXEL_STRIDE     = 1;

  // field widths
  localparam int unsigned COORD_W = 12;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned PIX_W   = 13;
  localparam int unsigned POS_W   = 14;
  localparam int unsigned OFS_W   = 20;
  localparam int unsigned COLOR_W = 16;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // one classified item as it travels through the queue
  typedef struct packed {
    cmd_e                      cmd;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic                      neg_x;
    logic                      neg_y;
    logic                      x_major;
    logic [LEN_W-1:0]          major_len;
    logic [LEN_W-1:0]          minor_len;
    logic [COLOR_W-1:0]        color;
  } cmd_t;

  // queue status seen by the two sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/clps_in_if.sv @@
`default_nettype none

interface clps_in_if import clps_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [COLOR_W-1:0]        line_color;

  modport source (
    output valid, action, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );
  modport sink (
    input  valid, action, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/clps_out_if.sv @@
`default_nettype none

interface clps_out_if import clps_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    busy_res;
  logic                    write_enable;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic [OFS_W-1:0]        byte_offset;
  logic [COLOR_W-1:0]      pixel_color;
  logic                    last;

  modport source (
    output valid, busy_res, write_enable, pixel_x, pixel_y, byte_offset,
           pixel_color, last,
    input  ready
  );
  modport sink (
    input  valid, busy_res, write_enable, pixel_x, pixel_y, byte_offset,
           pixel_color, last,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/clps_front.sv @@
`default_nettype none

module clps_front import clps_pkg::*; (
  clps_in_if.sink   in_i,
  input  q_status_t q_status_i,
  output logic      push_o,
  output cmd_t      cmd_o
);

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic [LEN_W-1:0]        len_x;
  logic [LEN_W-1:0]        len_y;
  logic                    x_major;

  // signed deltas between the endpoints
  assign dx = $signed({in_i.end_x[COORD_W-1], in_i.end_x})
            - $signed({in_i.start_x[COORD_W-1], in_i.start_x});
  assign dy = $signed({in_i.end_y[COORD_W-1], in_i.end_y})
            - $signed({in_i.start_y[COORD_W-1], in_i.start_y});

  // magnitudes and major axis, x wins a tie
  assign len_x   = dx[COORD_W] ? LEN_W'(-dx) : dx[LEN_W-1:0];
  assign len_y   = dy[COORD_W] ? LEN_W'(-dy) : dy[LEN_W-1:0];
  assign x_major = (len_x >= len_y);

  // classified command into the queue
  always_comb begin
    cmd_o           = '0;
    cmd_o.cmd       = in_i.action ? CMD_STEP : CMD_START;
    cmd_o.origin_x  = in_i.start_x;
    cmd_o.origin_y  = in_i.start_y;
    cmd_o.neg_x     = dx[COORD_W];
    cmd_o.neg_y     = dy[COORD_W];
    cmd_o.x_major   = x_major;
    cmd_o.major_len = x_major ? len_x : len_y;
    cmd_o.minor_len = x_major ? len_y : len_x;
    cmd_o.color     = in_i.line_color;
  end

  // transfer whenever the queue has room
  assign in_i.ready = !q_status_i.full;
  assign push_o     = in_i.valid && !q_status_i.full;

endmodule

`default_nettype wire

@@ hw/rtl/clps_queue.sv @@
`default_nettype none

module clps_queue import clps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      data_i,
  input  logic      pop_i,
  output cmd_t      data_o,
  output q_status_t status_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

@@ hw/rtl/clps_back.sv @@
`default_nettype none

module clps_back import clps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  input  cmd_t       cmd_i,
  input  q_status_t  q_status_i,
  output logic       pop_o,
  clps_out_if.source out_o
);

  // line state
  logic                    frame_q;
  logic                    line_active_q;
  logic                    x_major_q;
  logic                    neg_x_q;
  logic                    neg_y_q;
  logic [LEN_W-1:0]        major_q;
  logic [LEN_W-1:0]        minor_q;
  logic [LEN_W-1:0]        idx_q;
  logic [LEN_W-1:0]        rem_q;
  logic signed [POS_W-1:0] px_q;
  logic signed [POS_W-1:0] py_q;
  logic [COLOR_W-1:0]      color_q;

  // output register
  logic                    out_valid_q;
  logic                    busy_q;
  logic                    we_q;
  logic signed [PIX_W-1:0] pix_x_q;
  logic signed [PIX_W-1:0] pix_y_q;
  logic [OFS_W-1:0]        ofs_q;
  logic [COLOR_W-1:0]      pix_color_q;
  logic                    last_q;

  logic                    can_load;
  logic                    step_fire;
  logic                    start_fire;
  logic                    in_window;
  logic                    fin;
  logic [OFS_W-1:0]        offset;
  logic [LEN_W:0]          rem_sum;
  logic                    carry;
  logic [LEN_W-1:0]        rem_d;
  logic                    move_x;
  logic                    move_y;

  // pop a start at once, a step only when the output register is free
  assign can_load   = !out_valid_q || out_o.ready;
  assign pop_o      = !q_status_i.empty && ((cmd_i.cmd == CMD_START) || can_load);
  assign step_fire  = pop_o && (cmd_i.cmd == CMD_STEP);
  assign start_fire = pop_o && (cmd_i.cmd == CMD_START);

  // window test and frame offset of the current pixel
  assign in_window = !px_q[POS_W-1] && (px_q != '0)
                  && (px_q[PIX_W-1:0] < PIX_W'(SCREEN_WIDTH_PX))
                  && !py_q[POS_W-1] && (py_q != '0)
                  && (py_q[PIX_W-1:0] < PIX_W'(SCREEN_HEIGHT_PX));
  assign offset = (frame_q ? OFS_W'(FRAME_BYTES) : '0)
                + OFS_W'(px_q[PIX_W-1:0]) * OFS_W'(PIXEL_STRIDE * 2)
                + OFS_W'(py_q[PIX_W-1:0]) * OFS_W'(ROW_PITCH_PIXELS * 2);
  assign fin = (({1'b0, idx_q} + 1'b1) == {1'b0, major_q});

  // incremental minor-axis quotient: remainder steps by minor, wraps at major
  assign rem_sum = {1'b0, rem_q} + {1'b0, minor_q};
  assign carry   = (rem_sum >= {1'b0, major_q});
  assign rem_d   = carry ? LEN_W'(rem_sum - {1'b0, major_q}) : rem_sum[LEN_W-1:0];
  assign move_x  = x_major_q || carry;
  assign move_y  = !x_major_q || carry;

  // draw frame register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= 1'b0;
    end else if (cfg_we_i) begin
      frame_q <= cfg_data_i;
    end
  end

  // line control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q <= 1'b0;
      x_major_q     <= 1'b1;
      neg_x_q       <= 1'b0;
      neg_y_q       <= 1'b0;
      major_q       <= '0;
      minor_q       <= '0;
      idx_q         <= '0;
      rem_q         <= '0;
    end else if (start_fire) begin
      line_active_q <= (cmd_i.major_len != '0);
      x_major_q     <= cmd_i.x_major;
      neg_x_q       <= cmd_i.neg_x;
      neg_y_q       <= cmd_i.neg_y;
      major_q       <= cmd_i.major_len;
      minor_q       <= cmd_i.minor_len;
      idx_q         <= '0;
      rem_q         <= '0;
    end else if (step_fire && line_active_q) begin
      if (fin) begin
        line_active_q <= 1'b0;
        idx_q         <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
        rem_q <= rem_d;
      end
    end
  end

  // current position and colour
  always_ff @(posedge clk_i) begin
    if (start_fire) begin
      px_q    <= POS_W'(cmd_i.origin_x);
      py_q    <= POS_W'(cmd_i.origin_y);
      color_q <= cmd_i.color;
    end else if (step_fire && line_active_q && !fin) begin
      if (move_x) begin
        px_q <= neg_x_q ? px_q - POS_W'(1) : px_q + POS_W'(1);
      end
      if (move_y) begin
        py_q <= neg_y_q ? py_q - POS_W'(1) : py_q + POS_W'(1);
      end
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_load) begin
      out_valid_q <= step_fire;
    end
  end

  // output payload, all zero when no line is in progress
  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      if (line_active_q) begin
        busy_q      <= 1'b1;
        we_q        <= in_window;
        pix_x_q     <= px_q[PIX_W-1:0];
        pix_y_q     <= py_q[PIX_W-1:0];
        ofs_q       <= in_window ? offset : '0;
        pix_color_q <= color_q;
        last_q      <= fin;
      end else begin
        busy_q      <= 1'b0;
        we_q        <= 1'b0;
        pix_x_q     <= '0;
        pix_y_q     <= '0;
        ofs_q       <= '0;
        pix_color_q <= '0;
        last_q      <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.busy_res     = busy_q;
  assign out_o.write_enable = we_q;
  assign out_o.pixel_x      = pix_x_q;
  assign out_o.pixel_y      = pix_y_q;
  assign out_o.byte_offset  = ofs_q;
  assign out_o.pixel_color  = pix_color_q;
  assign out_o.last         = last_q;

`ifndef ASSERT_OFF
  a_rem_below_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q |-> (rem_q < major_q))
    else $error("minor remainder reached the major length");

  a_idx_below_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q |-> (idx_q < major_q))
    else $error("step index ran past the line end");

  a_idle_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !busy_q) |-> (!we_q && !last_q && (ofs_q == '0)
      && (pix_x_q == '0) && (pix_y_q == '0) && (pix_color_q == '0)))
    else $error("idle step result carries nonzero fields");

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && line_active_q && fin) |=> !line_active_q)
    else $error("line still active after its final pixel");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/clipped_line_pixel_stepper.sv @@
// path: a step item is stored in the queue, then popped into the output register
// throughput: one item per cycle while the output is ready; the output register and the queue refill each cycle
// a stalled output holds steps in the two-entry queue; start items still drain from it
// reset: asynchronous active low; no line in progress, draw frame 0, queue empty
`default_nettype none

module clipped_line_pixel_stepper import clps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_data_i,
  clps_in_if.sink    in_i,
  clps_out_if.source out_o
);

  logic      push;
  logic      pop;
  cmd_t      cmd_in;
  cmd_t      cmd_out;
  q_status_t q_status;

  // classify incoming items
  clps_front u_front (
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  // decoupling queue
  clps_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (cmd_in),
    .pop_i    (pop),
    .data_o   (cmd_out),
    .status_o (q_status)
  );

  // line stepping and pixel output
  clps_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd_out),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
